>>> rtl/muskingum_cunge_coefficients_macros.svh
// assertion macros for the muskingum-cunge coefficient block
`ifndef MUSKINGUM_CUNGE_COEFFICIENTS_MACROS_SVH
`define MUSKINGUM_CUNGE_COEFFICIENTS_MACROS_SVH

// same-cycle implication, checked out of reset
`define MCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcc assertion failed");

// next-cycle implication, checked out of reset
`define MCC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mcc assertion failed");

`endif

>>> rtl/mcc_pkg.sv
// shared constants and types for the muskingum-cunge coefficient block
`default_nettype none

package mcc_pkg;

    localparam int IDX_W      = 20;
    localparam int FLD_W      = 32;
    localparam int DT_W       = 17;
    localparam int COEF_W     = 17;
    localparam int COEF_FRAC  = 16;
    localparam int COUR_W     = 32;
    localparam int CD_BITS    = 48;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 112;

    localparam logic [DT_W-1:0]   DT_RESET = 17'd86400;
    localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;
    localparam logic [31:0]       BETA_OFS = 32'd65536;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NEG_COEF = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> rtl/mcc_div_cell.sv
// one restoring division cell: decides one quotient bit per lane
`default_nettype none

module mcc_div_cell #(
    parameter int LANES = 1,
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int Q_W   = 8,
    parameter int BIT   = 0,
    parameter int SB_W  = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [LANES-1:0][NUM_W-1:0]     i_rem,
    input  logic [LANES-1:0][DEN_W-1:0]     i_den,
    input  logic [LANES-1:0][Q_W-1:0]       i_quo,
    input  logic [SB_W-1:0]                 i_side,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [LANES-1:0][NUM_W-1:0]     o_rem,
    output logic [LANES-1:0][DEN_W-1:0]     o_den,
    output logic [LANES-1:0][Q_W-1:0]       o_quo,
    output logic [SB_W-1:0]                 o_side
);

    localparam int CMP_W = NUM_W + DEN_W + BIT;

    logic                        r_v;
    logic [LANES-1:0][NUM_W-1:0] r_rem, n_rem;
    logic [LANES-1:0][DEN_W-1:0] r_den;
    logic [LANES-1:0][Q_W-1:0]   r_quo, n_quo;
    logic [SB_W-1:0]             r_side;

    always_comb begin
        logic [CMP_W-1:0] trial;
        logic [CMP_W-1:0] rem_x;
        for (int l = 0; l < LANES; l++) begin
            trial = CMP_W'(i_den[l]) << BIT;
            rem_x = CMP_W'(i_rem[l]);
            if (rem_x >= trial) begin
                n_rem[l] = NUM_W'(rem_x - trial);
                n_quo[l] = i_quo[l] | (Q_W'(1) << BIT);
            end else begin
                n_rem[l] = i_rem[l];
                n_quo[l] = i_quo[l];
            end
        end
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

`default_nettype wire

>>> rtl/mcc_div_chain.sv
// row of division cells, most significant quotient bit first
`default_nettype none

module mcc_div_chain #(
    parameter int LANES = 1,
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int Q_W   = 8,
    parameter int SB_W  = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [LANES-1:0][NUM_W-1:0]     i_rem,
    input  logic [LANES-1:0][DEN_W-1:0]     i_den,
    input  logic [SB_W-1:0]                 i_side,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [LANES-1:0][Q_W-1:0]       o_quo,
    output logic [SB_W-1:0]                 o_side
);

    logic [Q_W-1:0]              w_v;
    logic [Q_W-1:0]              w_r;
    logic [LANES-1:0][NUM_W-1:0] w_rem  [Q_W];
    logic [LANES-1:0][DEN_W-1:0] w_den  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   w_quo  [Q_W];
    logic [SB_W-1:0]             w_side [Q_W];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = i_rem;
    assign w_den[0]  = i_den;
    assign w_quo[0]  = '0;
    assign w_side[0] = i_side;
    assign o_ready   = w_r[0];

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        if (g < Q_W - 1) begin : g_mid
            mcc_div_cell #(
                .LANES(LANES), .NUM_W(NUM_W), .DEN_W(DEN_W),
                .Q_W(Q_W), .BIT(Q_W - 1 - g), .SB_W(SB_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_v[g]),
                .o_ready (w_r[g]),
                .i_rem   (w_rem[g]),
                .i_den   (w_den[g]),
                .i_quo   (w_quo[g]),
                .i_side  (w_side[g]),
                .o_valid (w_v[g+1]),
                .i_ready (w_r[g+1]),
                .o_rem   (w_rem[g+1]),
                .o_den   (w_den[g+1]),
                .o_quo   (w_quo[g+1]),
                .o_side  (w_side[g+1])
            );
        end else begin : g_last
            mcc_div_cell #(
                .LANES(LANES), .NUM_W(NUM_W), .DEN_W(DEN_W),
                .Q_W(Q_W), .BIT(0), .SB_W(SB_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_v[g]),
                .o_ready (w_r[g]),
                .i_rem   (w_rem[g]),
                .i_den   (w_den[g]),
                .i_quo   (w_quo[g]),
                .i_side  (w_side[g]),
                .o_valid (o_valid),
                .i_ready (i_ready),
                .o_rem   (),
                .o_den   (),
                .o_quo   (o_quo),
                .o_side  (o_side)
            );
        end
    end

endmodule

`default_nettype wire

>>> rtl/muskingum_cunge_coefficients.sv
// an item passes stages a to g, with a row of division cells after a, e and f
// one item per cycle unless stalled, set by the rows of one-bit division cells
// (FRAC_BITS cells for xi, 48 for courant and diffusion, 17 for the coefficients)
// every stage has its own register and ready, so bubbles close up under stall
// reset clears all valid flags and loads the time step with 86400, no clearing pass
`default_nettype none

`include "muskingum_cunge_coefficients_macros.svh"

module muskingum_cunge_coefficients
    import mcc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DT_W-1:0]       i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cell_index, cell_length, bed_slope, mean_depth, mean_width, mean_velocity,
    // shape_exponent, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cell_echo, coeff_current_inflow, coeff_previous_inflow,
    // coeff_previous_outflow, courant_number, status, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int F      = FRAC_BITS;
    localparam int XN_W   = 32 + F;
    localparam int XD_W   = 34;
    localparam int XI_W   = F + 1;
    localparam int XV_W   = XI_W + 31;
    localparam int XVL    = XV_W / 2;
    localparam int XVH    = XV_W - XVL;
    localparam int LS_W   = 62;
    localparam int CN_W   = XV_W + DT_W;
    localparam int CD_W   = 39;
    localparam int DK_W   = 41;
    localparam int DN_W   = DK_W + 8 + 2 * F;
    localparam int DD_W   = LS_W + XI_W;
    localparam int NUM_W  = DN_W;
    localparam int DEN_W  = DD_W;
    localparam int SAT_W  = DEN_W + CD_BITS + 1;
    localparam int S_W    = CD_BITS + 1;
    localparam int KD_W   = CD_BITS + 2;
    localparam int KN_W   = KD_W + COEF_FRAC;
    localparam int SH_R   = (F >= 16) ? F - 16 : 0;
    localparam int SH_L   = (F < 16) ? 16 - F : 0;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [30:0]      len;
        logic [30:0]      slope;
        logic [30:0]      depth;
        logic [30:0]      vel;
        logic [DT_W-1:0]  dt;
        logic             inval;
    } t_xside;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             inval;
        logic             c_sat;
        logic             d_sat;
    } t_eside;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [COUR_W-1:0] courant;
        t_status           status;
    } t_kside;

    function automatic logic positive(input logic [FLD_W-1:0] v);
        return (v != '0) && !v[FLD_W-1];
    endfunction

    // configuration
    logic [DT_W-1:0] r_dt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RESET;
        end else if (i_cfg_valid) begin
            r_dt <= i_cfg_data;
        end
    end

    // input fields
    logic [IDX_W-1:0] in_idx;
    logic [FLD_W-1:0] in_len, in_slope, in_depth, in_width, in_vel, in_beta;

    assign in_idx   = s_axis_tdata[19:0];
    assign in_len   = s_axis_tdata[51:20];
    assign in_slope = s_axis_tdata[83:52];
    assign in_depth = s_axis_tdata[115:84];
    assign in_width = s_axis_tdata[147:116];
    assign in_vel   = s_axis_tdata[179:148];
    assign in_beta  = s_axis_tdata[211:180];

    // stage a: input register
    logic        r_a_v, rdy_a;
    t_xside      r_a_side;
    logic [30:0] r_a_beta;
    logic        x_in_ready;

    assign rdy_a         = !r_a_v || x_in_ready;
    assign s_axis_tready = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (rdy_a) begin
            r_a_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && s_axis_tvalid) begin
            r_a_side.idx   <= in_idx;
            r_a_side.len   <= in_len[30:0];
            r_a_side.slope <= in_slope[30:0];
            r_a_side.depth <= in_depth[30:0];
            r_a_side.vel   <= in_vel[30:0];
            r_a_side.dt    <= r_dt;
            r_a_side.inval <= !(positive(in_len) && positive(in_slope) &&
                                positive(in_depth) && positive(in_width) &&
                                positive(in_vel) && positive(in_beta));
            r_a_beta       <= in_beta[30:0];
        end
    end

    // xi division: 2*beta*2^F / (3*(beta + 1.0))
    logic [0:0][XN_W-1:0] x_rem;
    logic [0:0][XD_W-1:0] x_den;
    logic [XD_W-1:0]      x_bsum;
    logic [0:0][F-1:0]    x_quo;
    logic [$bits(t_xside)-1:0] x_side_o;
    logic                 x_v;
    t_xside               x_side;
    logic                 rdy_b;

    assign x_bsum   = XD_W'(r_a_beta) + XD_W'(BETA_OFS);
    assign x_rem[0] = XN_W'(r_a_beta) << (F + 1);
    assign x_den[0] = (x_bsum << 1) + x_bsum;
    assign x_side   = t_xside'(x_side_o);

    mcc_div_chain #(
        .LANES(1), .NUM_W(XN_W), .DEN_W(XD_W), .Q_W(F), .SB_W($bits(t_xside))
    ) u_xi_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .o_ready (x_in_ready),
        .i_rem   (x_rem),
        .i_den   (x_den),
        .i_side  (r_a_side),
        .o_valid (x_v),
        .i_ready (rdy_b),
        .o_quo   (x_quo),
        .o_side  (x_side_o)
    );

    // stage b: xi, xi*v and L*slope
    logic             r_b_v, rdy_c;
    logic [XI_W-1:0]  r_b_xi, b_xi;
    logic [XV_W-1:0]  r_b_xv;
    logic [LS_W-1:0]  r_b_ls;
    logic [IDX_W-1:0] r_b_idx;
    logic [30:0]      r_b_depth, r_b_len;
    logic [DT_W-1:0]  r_b_dt;
    logic             r_b_inval;

    assign rdy_b = !r_b_v || rdy_c;
    assign b_xi  = XI_W'(x_quo[0]) | (XI_W'(1) << F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (rdy_b) begin
            r_b_v <= x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && x_v) begin
            r_b_xi    <= b_xi;
            r_b_xv    <= XV_W'(b_xi) * XV_W'(x_side.vel);
            r_b_ls    <= LS_W'(x_side.len) * LS_W'(x_side.slope);
            r_b_idx   <= x_side.idx;
            r_b_depth <= x_side.depth;
            r_b_len   <= x_side.len;
            r_b_dt    <= x_side.dt;
            r_b_inval <= x_side.inval;
        end
    end

    // stage c: partial products
    logic                  r_c_v, rdy_d;
    logic [XVL+DT_W-1:0]   r_c_pvl;
    logic [XVH+DT_W-1:0]   r_c_pvh;
    logic [31+XI_W-1:0]    r_c_pll, r_c_plh;
    logic [DK_W-1:0]       r_c_dk;
    logic [IDX_W-1:0]      r_c_idx;
    logic [30:0]           r_c_len;
    logic                  r_c_inval;

    assign rdy_c = !r_c_v || rdy_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (rdy_c) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_b_v) begin
            r_c_pvl   <= (XVL+DT_W)'(r_b_xv[XVL-1:0]) * (XVL+DT_W)'(r_b_dt);
            r_c_pvh   <= (XVH+DT_W)'(r_b_xv[XV_W-1:XVL]) * (XVH+DT_W)'(r_b_dt);
            r_c_pll   <= (31+XI_W)'(r_b_ls[30:0]) * (31+XI_W)'(r_b_xi);
            r_c_plh   <= (31+XI_W)'(r_b_ls[61:31]) * (31+XI_W)'(r_b_xi);
            r_c_dk    <= DK_W'(r_b_depth) * DK_W'(10'd1000);
            r_c_idx   <= r_b_idx;
            r_c_len   <= r_b_len;
            r_c_inval <= r_b_inval;
        end
    end

    // stage d: dividends and divisors
    logic             r_d_v, rdy_e;
    logic [CN_W-1:0]  r_d_cn;
    logic [CD_W-1:0]  r_d_cd;
    logic [DN_W-1:0]  r_d_dn;
    logic [DD_W-1:0]  r_d_dd;
    logic [IDX_W-1:0] r_d_idx;
    logic             r_d_inval;

    assign rdy_d = !r_d_v || rdy_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (rdy_d) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_d && r_c_v) begin
            r_d_cn    <= (CN_W'(r_c_pvh) << XVL) + CN_W'(r_c_pvl);
            r_d_dd    <= (DD_W'(r_c_plh) << 31) + DD_W'(r_c_pll);
            r_d_dn    <= DN_W'(r_c_dk) << (8 + 2 * F);
            r_d_cd    <= CD_W'(r_c_len) << 8;
            r_d_idx   <= r_c_idx;
            r_d_inval <= r_c_inval;
        end
    end

    // stage e: saturation checks, load the courant and diffusion division
    logic                        r_e_v;
    logic [1:0][NUM_W-1:0]       r_e_rem;
    logic [1:0][DEN_W-1:0]       r_e_den;
    t_eside                      r_e_side;
    logic                        cd_in_ready;

    assign rdy_e = !r_e_v || cd_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (rdy_e) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_e && r_d_v) begin
            r_e_rem[0]     <= NUM_W'(r_d_cn);
            r_e_rem[1]     <= NUM_W'(r_d_dn);
            r_e_den[0]     <= DEN_W'(r_d_cd);
            r_e_den[1]     <= DEN_W'(r_d_dd);
            r_e_side.idx   <= r_d_idx;
            r_e_side.inval <= r_d_inval;
            r_e_side.c_sat <= SAT_W'(r_d_cn) >= (SAT_W'(r_d_cd) << CD_BITS);
            r_e_side.d_sat <= SAT_W'(r_d_dn) >= (SAT_W'(r_d_dd) << CD_BITS);
        end
    end

    logic [1:0][CD_BITS-1:0]   cd_quo;
    logic [$bits(t_eside)-1:0] cd_side_o;
    t_eside                    cd_side;
    logic                      cd_v, rdy_f;

    assign cd_side = t_eside'(cd_side_o);

    mcc_div_chain #(
        .LANES(2), .NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(CD_BITS), .SB_W($bits(t_eside))
    ) u_cd_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_v),
        .o_ready (cd_in_ready),
        .i_rem   (r_e_rem),
        .i_den   (r_e_den),
        .i_side  (r_e_side),
        .o_valid (cd_v),
        .i_ready (rdy_f),
        .o_quo   (cd_quo),
        .o_side  (cd_side_o)
    );

    // stage f: fallback test, courant output, coefficient numerators
    logic [CD_BITS-1:0] f_cf, f_df;
    logic [S_W-1:0]     f_sum, f_one_s;
    logic [KD_W-1:0]    f_one, f_den, f_n0, f_n1, f_n2;
    logic [63:0]        f_sh;
    logic [COUR_W-1:0]  f_cour;
    logic               f_neg;
    t_status            f_status;

    always_comb begin
        f_cf    = cd_side.c_sat ? '1 : cd_quo[0];
        f_df    = cd_side.d_sat ? '1 : cd_quo[1];
        f_one_s = S_W'(1) << F;
        f_one   = KD_W'(1) << F;
        f_sum   = S_W'(f_cf) + S_W'(f_df);
        f_neg   = (f_sum < f_one_s) || ((S_W'(f_cf) + f_one_s) < S_W'(f_df)) ||
                  ((S_W'(f_df) + f_one_s) < S_W'(f_cf));
        f_den   = KD_W'(f_sum) + f_one;
        f_n0    = KD_W'(f_sum) - f_one;
        f_n1    = f_one + KD_W'(f_cf) - KD_W'(f_df);
        f_n2    = f_one + KD_W'(f_df) - KD_W'(f_cf);
        f_sh    = (64'(f_cf) << SH_L) >> SH_R;
        f_cour  = (f_sh[63:32] != '0) ? '1 : f_sh[31:0];
        if (cd_side.inval) begin
            f_status = ST_INVALID;
            f_cour   = '0;
        end else if (f_neg) begin
            f_status = ST_NEG_COEF;
        end else begin
            f_status = ST_OK;
        end
    end

    logic                   r_f_v;
    logic [2:0][KN_W-1:0]   r_f_rem;
    logic [2:0][KD_W-1:0]   r_f_den;
    t_kside                 r_f_side;
    logic                   k_in_ready;

    assign rdy_f = !r_f_v || k_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (rdy_f) begin
            r_f_v <= cd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_f && cd_v) begin
            r_f_rem[0]       <= KN_W'(f_n0) << COEF_FRAC;
            r_f_rem[1]       <= KN_W'(f_n1) << COEF_FRAC;
            r_f_rem[2]       <= KN_W'(f_n2) << COEF_FRAC;
            r_f_den[0]       <= f_den;
            r_f_den[1]       <= f_den;
            r_f_den[2]       <= f_den;
            r_f_side.idx     <= cd_side.idx;
            r_f_side.courant <= f_cour;
            r_f_side.status  <= f_status;
        end
    end

    logic [2:0][COEF_W-1:0]    k_quo;
    logic [$bits(t_kside)-1:0] k_side_o;
    t_kside                    k_side;
    logic                      k_v, rdy_g;

    assign k_side = t_kside'(k_side_o);

    mcc_div_chain #(
        .LANES(3), .NUM_W(KN_W), .DEN_W(KD_W), .Q_W(COEF_W), .SB_W($bits(t_kside))
    ) u_coef_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .o_ready (k_in_ready),
        .i_rem   (r_f_rem),
        .i_den   (r_f_den),
        .i_side  (r_f_side),
        .o_valid (k_v),
        .i_ready (rdy_g),
        .o_quo   (k_quo),
        .o_side  (k_side_o)
    );

    // stage g: output register
    logic              r_g_v;
    logic [IDX_W-1:0]  r_g_idx;
    logic [COEF_W-1:0] r_g_c0, r_g_c1, r_g_c2;
    logic [COUR_W-1:0] r_g_cour;
    t_status           r_g_status;
    logic [COEF_W+1:0] w_coef_sum;

    assign rdy_g = !r_g_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (rdy_g) begin
            r_g_v <= k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_g && k_v) begin
            r_g_idx    <= k_side.idx;
            r_g_cour   <= k_side.courant;
            r_g_status <= k_side.status;
            if (k_side.status == ST_OK) begin
                r_g_c0 <= k_quo[0];
                r_g_c1 <= k_quo[1];
                r_g_c2 <= k_quo[2];
            end else begin
                r_g_c0 <= COEF_ONE;
                r_g_c1 <= '0;
                r_g_c2 <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_g_v;
    assign m_axis_tdata  = {7'b0, r_g_status, r_g_cour, r_g_c2, r_g_c1, r_g_c0, r_g_idx};

    assign w_coef_sum = (COEF_W+2)'(r_g_c0) + (COEF_W+2)'(r_g_c1) + (COEF_W+2)'(r_g_c2);

    `MCC_ASSERT_IMP(a_invalid_no_courant, r_g_v && (r_g_status == ST_INVALID), r_g_cour == '0)
    `MCC_ASSERT_IMP(a_fallback_coefs, r_g_v && (r_g_status != ST_OK), (r_g_c0 == COEF_ONE) && (r_g_c1 == '0) && (r_g_c2 == '0))
    `MCC_ASSERT_IMP(a_coef_sum, r_g_v && (r_g_status == ST_OK), (w_coef_sum <= (COEF_W+2)'(COEF_ONE)) && (w_coef_sum + (COEF_W+2)'(2) >= (COEF_W+2)'(COEF_ONE)))
    `MCC_ASSERT_NXT(a_cfg_write, i_cfg_valid, r_dt == $past(i_cfg_data))

endmodule

`default_nettype wire
